@@ design/ile_pkg.sv @@
// Shared types and constants for the indexed list engine.
// Depends on nothing; every other design file refers to it by scoped names.
package ile_pkg;

    localparam int FUNC_W      = 4;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int LEN_W       = 6;
    localparam int MAX_RESULTS = 32;

    // Input word layout, lowest bit first: func, position, value, zero pad.
    localparam int FUNC_LSB    = 0;
    localparam int POS_LSB     = FUNC_LSB + FUNC_W;
    localparam int VAL_LSB     = POS_LSB + POS_W;
    localparam int S_PAYLOAD_W = VAL_LSB + VAL_W;
    localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VAL_W + STAT_W + LEN_W + 7) / 8) * 8;

    // Request codes.
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd2;
    localparam logic [FUNC_W-1:0] FN_UPDATE    = 4'd3;
    localparam logic [FUNC_W-1:0] FN_REM_AT    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REM_FRONT = 4'd5;
    localparam logic [FUNC_W-1:0] FN_REM_END   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_REVERSE   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_DUMP      = 4'd8;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_READ,
        S_REM_GOT,
        S_REM_SHIFT,
        S_REV_RD_J,
        S_REV_WR_I,
        S_REV_WR_J,
        S_DUMP,
        S_FINISH
    } state_t;

    // Result word layout, lowest bit first: value_res, status, length.
    typedef struct packed {
        logic        [LEN_W-1:0]  length;
        logic        [STAT_W-1:0] status;
        logic signed [VAL_W-1:0]  value_res;
    } result_t;

endpackage

@@ design/ile_store.sv @@
// Element store of the indexed list engine: one write port, one read port,
// read data registered. Depends on ile_pkg for the element width.
module ile_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ile_pkg::VAL_W-1:0]  wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [ile_pkg::VAL_W-1:0]  rdata
);

    logic [ile_pkg::VAL_W-1:0] mem [DEPTH];
    logic [ile_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/indexed_list_engine.sv @@
// Top level of the indexed list engine: request sequencer, list length and
// result register. Depends on ile_pkg and ile_store.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements
// in a single-port-read, single-port-write memory. One request word enters
// on the s_ channel (func, position, value); results leave on the m_ channel
// as words carrying value_res, status and length, with m_tlast on the final
// word of a request. Every request gives one result word, except a dump of a
// non-empty list, which gives one word per element (at most 32) in order.
//
// Requests are handled one at a time. An insert or remove moves the elements
// between its position and the tail one by one, and a dump gives one word
// per cycle while the receiver takes them, after the first has been read.
// The memory allows one read and one write per cycle; the new element of an
// insert is written after the last moved one, and each swap of a reversal
// reads the low element, reads the high one, then writes both back.
// A new request is accepted as soon as the previous one has handed its last
// result word to the output register, even while that word still waits.
// If the receiver stalls, the result register holds its word and the
// sequencer waits; a dump resumes reading the store once the word is taken.
// Reset (aresetn low, synchronous) empties the list and clears both
// channels; the store contents are left as they are and are never read
// before being written again.
module indexed_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, lowest bit first: func[3:0], position[9:4], value[41:10],
    // zero pad[47:42].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ile_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata, lowest bit first: value_res[31:0], status[33:32],
    // length[39:34].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ile_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int XW     = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
    localparam int DUMP_N = (CAPACITY < ile_pkg::MAX_RESULTS) ? CAPACITY
                                                              : ile_pkg::MAX_RESULTS;

    // Request fields.
    logic [ile_pkg::FUNC_W-1:0]       s_func;
    logic [ile_pkg::POS_W-1:0]        s_position;
    logic signed [ile_pkg::VAL_W-1:0] s_value;

    assign s_func     = s_tdata[ile_pkg::FUNC_LSB +: ile_pkg::FUNC_W];
    assign s_position = s_tdata[ile_pkg::POS_LSB +: ile_pkg::POS_W];
    assign s_value    = s_tdata[ile_pkg::VAL_LSB +: ile_pkg::VAL_W];

    // Control and payload registers.
    ile_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   ptr_reg, ptr_next;
    logic [CW-1:0]                   op_pos_reg, op_pos_next;
    logic [AW-1:0]                   hi_reg, hi_next;
    logic [ile_pkg::VAL_W-1:0]       value_reg, value_next;
    logic [ile_pkg::VAL_W-1:0]       got_reg, got_next;
    logic [ile_pkg::VAL_W-1:0]       hold_reg, hold_next;
    logic [ile_pkg::STAT_W-1:0]      status_reg, status_next;
    logic                            wb_valid_reg, wb_valid_next;
    logic [AW-1:0]                   wb_addr_reg, wb_addr_next;
    logic                            m_valid_reg, m_valid_next;
    ile_pkg::result_t                m_res_reg, m_res_next;
    logic                            m_last_reg, m_last_next;

    // Store ports.
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [ile_pkg::VAL_W-1:0]       mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [ile_pkg::VAL_W-1:0]       mem_rdata;
    logic                            dir_we;
    logic [AW-1:0]                   dir_waddr;
    logic [ile_pkg::VAL_W-1:0]       dir_wdata;

    // Decode helpers.
    logic                            accept;
    logic                            out_free;
    logic                            push;
    ile_pkg::result_t                push_res;
    logic                            push_last;
    logic [XW-1:0]                   cnt_x;
    logic [XW-1:0]                   pos_x;
    logic [XW-1:0]                   op_pos_x;
    logic                            is_full;
    logic                            is_empty;
    logic                            ins_bad;
    logic                            idx_bad;
    logic                            rev_more;
    logic                            dump_last;
    logic                            rem_more;

    assign s_tready = (state_reg == ile_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cnt_x    = XW'(count_reg);
    assign pos_x    = XW'(s_position);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        case (s_func)
            ile_pkg::FN_INS_AT, ile_pkg::FN_UPDATE, ile_pkg::FN_REM_AT: begin
                op_pos_x = pos_x;
            end
            ile_pkg::FN_INS_END: begin
                op_pos_x = cnt_x;
            end
            ile_pkg::FN_REM_END: begin
                op_pos_x = cnt_x - XW'(1);
            end
            default: begin
                op_pos_x = '0;
            end
        endcase
    end

    assign ins_bad   = (op_pos_x > cnt_x);
    assign idx_bad   = (op_pos_x >= cnt_x);
    assign rev_more  = ((ptr_reg + CW'(1)) < (CW'(hi_reg) - CW'(1)));
    assign dump_last = (ptr_reg == count_reg) || (ptr_reg == CW'(DUMP_N));
    assign rem_more  = (ptr_reg < count_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ile_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_func)
                        ile_pkg::FN_INS_AT, ile_pkg::FN_INS_END,
                        ile_pkg::FN_INS_FRONT: begin
                            if (is_full || ins_bad) begin
                                state_next = ile_pkg::S_FINISH;
                            end else if (op_pos_x == cnt_x) begin
                                state_next = ile_pkg::S_INS_PUT;
                            end else begin
                                state_next = ile_pkg::S_INS_SHIFT;
                            end
                        end
                        ile_pkg::FN_REM_AT, ile_pkg::FN_REM_FRONT,
                        ile_pkg::FN_REM_END: begin
                            if (is_empty || idx_bad) begin
                                state_next = ile_pkg::S_FINISH;
                            end else begin
                                state_next = ile_pkg::S_REM_READ;
                            end
                        end
                        ile_pkg::FN_REVERSE: begin
                            if (count_reg > CW'(1)) begin
                                state_next = ile_pkg::S_REV_RD_J;
                            end else begin
                                state_next = ile_pkg::S_FINISH;
                            end
                        end
                        ile_pkg::FN_DUMP: begin
                            if (is_empty) begin
                                state_next = ile_pkg::S_FINISH;
                            end else begin
                                state_next = ile_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            state_next = ile_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            ile_pkg::S_INS_SHIFT: begin
                if (ptr_reg == op_pos_reg) begin
                    state_next = ile_pkg::S_INS_PUT;
                end
            end
            ile_pkg::S_INS_PUT: begin
                if (!wb_valid_reg) begin
                    state_next = ile_pkg::S_FINISH;
                end
            end
            ile_pkg::S_REM_READ: begin
                state_next = ile_pkg::S_REM_GOT;
            end
            ile_pkg::S_REM_GOT, ile_pkg::S_REM_SHIFT: begin
                if (rem_more) begin
                    state_next = ile_pkg::S_REM_SHIFT;
                end else begin
                    state_next = ile_pkg::S_FINISH;
                end
            end
            ile_pkg::S_REV_RD_J: begin
                state_next = ile_pkg::S_REV_WR_I;
            end
            ile_pkg::S_REV_WR_I: begin
                state_next = ile_pkg::S_REV_WR_J;
            end
            ile_pkg::S_REV_WR_J: begin
                if (rev_more) begin
                    state_next = ile_pkg::S_REV_RD_J;
                end else begin
                    state_next = ile_pkg::S_FINISH;
                end
            end
            ile_pkg::S_DUMP: begin
                if (out_free && dump_last) begin
                    state_next = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = ile_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, store accesses and result pushes.
    always_comb begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        op_pos_next   = op_pos_reg;
        hi_next       = hi_reg;
        value_next    = value_reg;
        got_next      = got_reg;
        hold_next     = hold_reg;
        status_next   = status_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        mem_re        = 1'b0;
        mem_raddr     = AW'(ptr_reg);
        dir_we        = 1'b0;
        dir_waddr     = AW'(op_pos_reg);
        dir_wdata     = value_reg;
        push          = 1'b0;
        push_last     = 1'b1;
        push_res      = '{length: ile_pkg::LEN_W'(count_reg), status: status_reg,
                          value_res: got_reg};

        case (state_reg)
            ile_pkg::S_IDLE: begin
                if (accept) begin
                    value_next  = s_value;
                    got_next    = '0;
                    status_next = ile_pkg::STAT_OK;
                    op_pos_next = CW'(op_pos_x);
                    case (s_func)
                        ile_pkg::FN_INS_AT, ile_pkg::FN_INS_END,
                        ile_pkg::FN_INS_FRONT: begin
                            if (is_full) begin
                                status_next = ile_pkg::STAT_FULL;
                            end else if (ins_bad) begin
                                status_next = ile_pkg::STAT_BAD_INDEX;
                            end
                            ptr_next = count_reg - CW'(1);
                        end
                        ile_pkg::FN_UPDATE: begin
                            if (is_empty) begin
                                status_next = ile_pkg::STAT_EMPTY;
                            end else if (idx_bad) begin
                                status_next = ile_pkg::STAT_BAD_INDEX;
                            end else begin
                                dir_we    = 1'b1;
                                dir_waddr = AW'(op_pos_x);
                                dir_wdata = s_value;
                            end
                        end
                        ile_pkg::FN_REM_AT, ile_pkg::FN_REM_FRONT,
                        ile_pkg::FN_REM_END: begin
                            if (is_empty) begin
                                status_next = ile_pkg::STAT_EMPTY;
                            end else if (idx_bad) begin
                                status_next = ile_pkg::STAT_BAD_INDEX;
                            end
                            ptr_next = CW'(op_pos_x);
                        end
                        ile_pkg::FN_REVERSE: begin
                            // Low index starts at zero, high index at the tail.
                            mem_re    = (count_reg > CW'(1));
                            mem_raddr = '0;
                            ptr_next  = '0;
                            hi_next   = AW'(count_reg - CW'(1));
                        end
                        ile_pkg::FN_DUMP: begin
                            if (is_empty) begin
                                status_next = ile_pkg::STAT_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                ptr_next  = CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ile_pkg::S_INS_SHIFT: begin
                // Move the tail up by one, highest element first; each read
                // is written one entry higher in the following cycle.
                mem_re        = 1'b1;
                wb_valid_next = 1'b1;
                wb_addr_next  = AW'(ptr_reg + CW'(1));
                if (ptr_reg != op_pos_reg) begin
                    ptr_next = ptr_reg - CW'(1);
                end
            end
            ile_pkg::S_INS_PUT: begin
                // The final shift write goes first, then the new element.
                if (!wb_valid_reg) begin
                    dir_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ile_pkg::S_REM_READ: begin
                mem_re   = 1'b1;
                ptr_next = ptr_reg + CW'(1);
            end
            ile_pkg::S_REM_GOT, ile_pkg::S_REM_SHIFT: begin
                if (state_reg == ile_pkg::S_REM_GOT) begin
                    got_next = mem_rdata;
                end
                if (rem_more) begin
                    mem_re        = 1'b1;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = AW'(ptr_reg - CW'(1));
                    ptr_next      = ptr_reg + CW'(1);
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            ile_pkg::S_REV_RD_J: begin
                mem_re    = 1'b1;
                mem_raddr = hi_reg;
                hold_next = mem_rdata;
            end
            ile_pkg::S_REV_WR_I: begin
                dir_we    = 1'b1;
                dir_waddr = AW'(ptr_reg);
                dir_wdata = mem_rdata;
            end
            ile_pkg::S_REV_WR_J: begin
                dir_we    = 1'b1;
                dir_waddr = hi_reg;
                dir_wdata = hold_reg;
                ptr_next  = ptr_reg + CW'(1);
                hi_next   = hi_reg - AW'(1);
                if (rev_more) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_reg + CW'(1));
                end
            end
            ile_pkg::S_DUMP: begin
                push_res  = '{length: ile_pkg::LEN_W'(count_reg),
                              status: ile_pkg::STAT_OK, value_res: mem_rdata};
                push_last = dump_last;
                if (out_free) begin
                    push = 1'b1;
                    if (!dump_last) begin
                        mem_re   = 1'b1;
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
            end
            ile_pkg::S_FINISH: begin
                push = out_free;
            end
            default: begin
            end
        endcase
    end

    // Shift write-backs and direct writes never fall in the same cycle.
    assign mem_we    = wb_valid_reg || dir_we;
    assign mem_waddr = wb_valid_reg ? wb_addr_reg : dir_waddr;
    assign mem_wdata = wb_valid_reg ? mem_rdata : dir_wdata;

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_res_next   = push_res;
            m_last_next  = push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ile_pkg::S_IDLE;
            count_reg    <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        op_pos_reg  <= op_pos_next;
        hi_reg      <= hi_next;
        value_reg   <= value_next;
        got_reg     <= got_next;
        hold_reg    <= hold_next;
        status_reg  <= status_next;
        wb_addr_reg <= wb_addr_next;
        m_res_reg   <= m_res_next;
        m_last_reg  <= m_last_next;
    end

    ile_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ile_pkg::M_TDATA_W'(m_res_reg);
    assign m_tlast  = m_last_reg;

endmodule

@@ design/ile_check.sv @@
// Port-level checker for the indexed list engine, bound to the top level.
// Depends on ile_pkg for the result word layout and status codes.
module ile_check #(
    parameter int CAPACITY = 32
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ile_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    ile_pkg::result_t res;

    assign res = m_tdata;

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Only a dump gives words before the last, and those are successful.
    a_mid_dump_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> res.status == ile_pkg::STAT_OK)
        else $error("non-final result word with failing status");

    // An empty report comes with an empty list and no value.
    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ile_pkg::STAT_EMPTY
        |-> res.length == '0 && res.value_res == '0 && m_tlast)
        else $error("empty status with elements or a value");

    // A full report comes with a full list and no value.
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ile_pkg::STAT_FULL
        |-> res.length == ile_pkg::LEN_W'(CAPACITY) && res.value_res == '0)
        else $error("full status with wrong length or a value");

endmodule

bind indexed_list_engine ile_check #(.CAPACITY(CAPACITY)) u_ile_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ test/indexed_list_engine_tb.sv @@
// Self-checking testbench for indexed_list_engine: a list scoreboard that
// predicts every result word, stream drivers and the run sequence.
// Depends on ile_pkg and the indexed_list_engine RTL only.
module indexed_list_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 32;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    // The slowest request is a reversal of a full list. With a receiver that
    // stalls in 71 percent of cycles, a quiet stretch as long as the watchdog
    // limit only happens if the block is stuck.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;

    // Request codes above dump are not decoded by the block.
    localparam logic [ile_pkg::FUNC_W-1:0] FN_UNUSED_LO = ile_pkg::FN_DUMP + 1'b1;
    localparam logic [ile_pkg::FUNC_W-1:0] FN_UNUSED_HI = '1;

    localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MIN =
        {1'b1, {(ile_pkg::VAL_W-1){1'b0}}};
    localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MAX =
        {1'b0, {(ile_pkg::VAL_W-1){1'b1}}};

    // One expected result word, in the field order of the result channel.
    typedef struct {
        logic signed [ile_pkg::VAL_W-1:0]  value_res;
        logic        [ile_pkg::STAT_W-1:0] status;
        logic        [ile_pkg::LEN_W-1:0]  length;
        logic                              last;
    } list_result_t;

    // Keeps a shadow copy of the list, turns every accepted request into the
    // result words it must produce, and compares the words as they arrive.
    class list_scoreboard;
        logic signed [ile_pkg::VAL_W-1:0] elems [CAPACITY];
        int unsigned                      count;
        list_result_t                     awaited[$];
        int                               mismatches;
        int                               words_checked;
        int                               requests;
        int                               dumps;
        int                               full_hits;
        int                               empty_hits;
        int                               bad_index_hits;

        function int pending();
            return awaited.size();
        endfunction

        function void push_word(logic signed [ile_pkg::VAL_W-1:0] v,
                                logic [ile_pkg::STAT_W-1:0] st, logic fin);
            list_result_t r;
            r.value_res = v;
            r.status    = st;
            r.length    = ile_pkg::LEN_W'(count);
            r.last      = fin;
            awaited.push_back(r);
        endfunction

        // Fullness is checked ahead of the index; an index equal to the
        // length appends.
        function logic [ile_pkg::STAT_W-1:0] insert_elem(int unsigned at,
                                                         logic signed [ile_pkg::VAL_W-1:0] v);
            int unsigned i;
            if (count >= CAPACITY) return ile_pkg::STAT_FULL;
            if (at > count) return ile_pkg::STAT_BAD_INDEX;
            for (i = count; i > at; i--) elems[i] = elems[i-1];
            elems[at] = v;
            count++;
            return ile_pkg::STAT_OK;
        endfunction

        function logic [ile_pkg::STAT_W-1:0] remove_elem(int unsigned at,
                output logic signed [ile_pkg::VAL_W-1:0] got);
            int unsigned i;
            got = '0;
            if (count == 0) return ile_pkg::STAT_EMPTY;
            if (at >= count) return ile_pkg::STAT_BAD_INDEX;
            got = elems[at];
            for (i = at; i + 1 < count; i++) elems[i] = elems[i+1];
            count--;
            return ile_pkg::STAT_OK;
        endfunction

        function void note_request(logic [ile_pkg::FUNC_W-1:0] fn,
                                   logic [ile_pkg::POS_W-1:0] pos,
                                   logic signed [ile_pkg::VAL_W-1:0] v);
            logic signed [ile_pkg::VAL_W-1:0] got;
            logic signed [ile_pkg::VAL_W-1:0] t;
            logic        [ile_pkg::STAT_W-1:0] st;
            int unsigned                      i;
            int unsigned                      j;
            int unsigned                      n;
            got = '0;
            st  = ile_pkg::STAT_OK;
            requests++;
            case (fn)
                ile_pkg::FN_INS_AT:    st = insert_elem(pos, v);
                ile_pkg::FN_INS_END:   st = insert_elem(count, v);
                ile_pkg::FN_INS_FRONT: st = insert_elem(0, v);
                ile_pkg::FN_UPDATE: begin
                    if (count == 0) st = ile_pkg::STAT_EMPTY;
                    else if (pos >= count) st = ile_pkg::STAT_BAD_INDEX;
                    else elems[pos] = v;
                end
                ile_pkg::FN_REM_AT:    st = remove_elem(pos, got);
                ile_pkg::FN_REM_FRONT: st = remove_elem(0, got);
                ile_pkg::FN_REM_END:   st = remove_elem((count == 0) ? 0 : count - 1, got);
                ile_pkg::FN_REVERSE: begin
                    if (count > 1) begin
                        i = 0;
                        j = count - 1;
                        while (i < j) begin
                            t        = elems[i];
                            elems[i] = elems[j];
                            elems[j] = t;
                            i++;
                            j--;
                        end
                    end
                end
                ile_pkg::FN_DUMP: begin
                    dumps++;
                    if (count == 0) begin
                        empty_hits++;
                        push_word('0, ile_pkg::STAT_EMPTY, 1'b1);
                    end else begin
                        n = (count < ile_pkg::MAX_RESULTS) ? count : ile_pkg::MAX_RESULTS;
                        for (i = 0; i < n; i++)
                            push_word(elems[i], ile_pkg::STAT_OK, i + 1 == n);
                    end
                    return;
                end
                default: ;
            endcase
            if (st == ile_pkg::STAT_FULL) full_hits++;
            if (st == ile_pkg::STAT_EMPTY) empty_hits++;
            if (st == ile_pkg::STAT_BAD_INDEX) bad_index_hits++;
            push_word(got, st, 1'b1);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [ile_pkg::M_TDATA_W-1:0] word, logic tlast);
            ile_pkg::result_t seen;
            list_result_t     want;
            seen = ile_pkg::result_t'(word);
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing outstanding", word));
                return;
            end
            want = awaited.pop_front();
            words_checked++;
            if (seen.value_res !== want.value_res)
                report_mismatch($sformatf("value_res %0d, predicted %0d",
                                          seen.value_res, want.value_res));
            if (seen.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          seen.status, want.status));
            if (seen.length !== want.length)
                report_mismatch($sformatf("length %0d, predicted %0d",
                                          seen.length, want.length));
            if (tlast !== want.last)
                report_mismatch($sformatf("tlast %b, predicted %b", tlast, want.last));
        endtask
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ile_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ile_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int                     in_idle   = 0;
    int                     out_stall = 0;
    int                     quiet_cycles = 0;

    list_scoreboard         sb;

    indexed_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // func, position, value, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // value_res, status, length
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // The receiver decides at every falling edge whether to take a word at
    // the next rising edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= out_stall);
    end

    // Result words are sampled at the rising edge, before the block's own
    // updates of that edge land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // Watchdog: a long stretch with no word moving on either channel means
    // the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d words outstanding",
                     WATCHDOG_LIMIT, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one request word, with random idle cycles ahead of it, and
    // waits for the block to accept it. The request is handed to the
    // scoreboard at the accepting edge.
    task send_request(logic [ile_pkg::FUNC_W-1:0] fn, logic [ile_pkg::POS_W-1:0] pos,
                      logic signed [ile_pkg::VAL_W-1:0] v);
        while ($urandom_range(99) < in_idle) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid                                        = 1'b1;
        s_tdata                                         = '0;
        s_tdata[ile_pkg::FUNC_LSB +: ile_pkg::FUNC_W]   = fn;
        s_tdata[ile_pkg::POS_LSB +: ile_pkg::POS_W]     = pos;
        s_tdata[ile_pkg::VAL_LSB +: ile_pkg::VAL_W]     = v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(fn, pos, v);
    endtask

    function logic signed [ile_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(99) >= 20) return $urandom;
        case ($urandom_range(4))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '1;
            3:       return '0;
            default: return 1;
        endcase
    endfunction

    // Random requests. The mix swings between growing the list until it is
    // full and shrinking it until it is empty, so that inserts into a full
    // list and removals from an empty one happen regularly; it lingers at
    // either end for a while before turning. Undecoded codes are sprinkled
    // in as noise and are not counted toward n.
    task run_random(int n);
        int                             sent;
        int                             r;
        logic [ile_pkg::FUNC_W-1:0]     fn;
        logic [ile_pkg::POS_W-1:0]      pos;
        bit                             growing;
        sent    = 0;
        growing = 1'b1;
        while (sent < n) begin
            if (growing && sb.count == CAPACITY && $urandom_range(99) < 30) growing = 1'b0;
            if (!growing && sb.count == 0 && $urandom_range(99) < 30) growing = 1'b1;
            r = $urandom_range(99);
            if (r >= 95) begin
                fn = ile_pkg::FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
            end else if (growing) begin
                if (r < 30)      fn = ile_pkg::FN_INS_AT;
                else if (r < 45) fn = ile_pkg::FN_INS_END;
                else if (r < 58) fn = ile_pkg::FN_INS_FRONT;
                else if (r < 68) fn = ile_pkg::FN_UPDATE;
                else if (r < 75) fn = ile_pkg::FN_REM_AT;
                else if (r < 80) fn = ile_pkg::FN_REM_FRONT;
                else if (r < 85) fn = ile_pkg::FN_REM_END;
                else if (r < 90) fn = ile_pkg::FN_REVERSE;
                else             fn = ile_pkg::FN_DUMP;
            end else begin
                // Shrinking: the insert and remove shares trade places.
                if (r < 10)      fn = ile_pkg::FN_INS_AT;
                else if (r < 15) fn = ile_pkg::FN_INS_END;
                else if (r < 20) fn = ile_pkg::FN_INS_FRONT;
                else if (r < 30) fn = ile_pkg::FN_UPDATE;
                else if (r < 50) fn = ile_pkg::FN_REM_AT;
                else if (r < 65) fn = ile_pkg::FN_REM_FRONT;
                else if (r < 80) fn = ile_pkg::FN_REM_END;
                else if (r < 87) fn = ile_pkg::FN_REVERSE;
                else             fn = ile_pkg::FN_DUMP;
            end
            // Mostly a valid index; now and then anything the field holds.
            if ($urandom_range(99) < 15) begin
                pos = ile_pkg::POS_W'($urandom_range(63));
            end else if (fn == ile_pkg::FN_INS_AT) begin
                pos = ile_pkg::POS_W'($urandom_range(sb.count));
            end else begin
                pos = ile_pkg::POS_W'($urandom_range((sb.count == 0) ? 0 : sb.count - 1));
            end
            send_request(fn, pos, pick_value());
            if (fn < FN_UNUSED_LO) sent++;
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: every request but the end and front inserts on an empty list,
        // single-element corner cases, value extremes, bad indexes and undecoded codes.
        send_request(ile_pkg::FN_DUMP,      0,  0);
        send_request(ile_pkg::FN_REM_FRONT, 0,  0);
        send_request(ile_pkg::FN_REM_END,   0,  0);
        send_request(ile_pkg::FN_REM_AT,    0,  0);
        send_request(ile_pkg::FN_UPDATE,    0,  VAL_MAX);
        send_request(ile_pkg::FN_REVERSE,   0,  0);
        send_request(ile_pkg::FN_INS_AT,    1,  VAL_MIN);      // beyond the length
        send_request(ile_pkg::FN_INS_AT,    0,  VAL_MAX);
        send_request(ile_pkg::FN_REVERSE,   0,  0);            // single element
        send_request(ile_pkg::FN_REM_END,   0,  0);            // removes the only element
        send_request(ile_pkg::FN_INS_END,   0,  VAL_MIN);
        send_request(ile_pkg::FN_INS_FRONT, 0,  -1);
        send_request(ile_pkg::FN_INS_AT,    2,  0);            // index equal to length
        send_request(ile_pkg::FN_INS_AT,    1,  32'h5a5a_a5a5);
        send_request(ile_pkg::FN_UPDATE,    63, 32'h0f0f_f0f0);
        send_request(ile_pkg::FN_UPDATE,    0,  32'h1234_5678);
        send_request(ile_pkg::FN_REM_AT,    4,  0);            // index equal to length
        send_request(ile_pkg::FN_REM_AT,    1,  0);
        send_request(ile_pkg::FN_REVERSE,   0,  0);
        send_request(ile_pkg::FN_DUMP,      0,  0);
        send_request(FN_UNUSED_HI,          21, VAL_MIN);
        send_request(FN_UNUSED_LO,          42, VAL_MAX);
        send_request(ile_pkg::FN_REM_FRONT, 0,  0);
        send_request(ile_pkg::FN_REM_AT,    63, 0);
        send_request(ile_pkg::FN_DUMP,      0,  0);

        // Random part in four handshake regimes.
        in_idle = 0;  out_stall = 0;  run_random(105);
        in_idle = 71; out_stall = 0;  run_random(105);
        in_idle = 0;  out_stall = 71; run_random(105);
        in_idle = 12; out_stall = 12; run_random(105);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests with %0d dumps; %0d result words checked.",
                 sb.requests, sb.dumps, sb.words_checked);
        $display("Rejections seen: %0d full, %0d empty, %0d bad index; %0d mismatches.",
                 sb.full_hits, sb.empty_hits, sb.bad_index_hits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/ile_pkg.sv
design/ile_store.sv
design/indexed_list_engine.sv
design/ile_check.sv
test/indexed_list_engine_tb.sv
